// ----- rtl/core/hpca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpca_pkg: shared types and constants of the chunk slot allocator
// Holds the transfer payload types, the mode and status codes, the slot
// word layout and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package hpca_pkg;

  // Fixed field widths.
  localparam int KEY_W    = 64;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 8;
  localparam int OFFSET_W = 20;
  localparam int CFG_W    = 9;

  // Every byte offset starts past a fixed header.
  localparam int HEADER_BYTES = 16;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVICT   = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Request payload.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  number;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot_index;
    logic [OFFSET_W-1:0] byte_offset;
  } rsp_t;

  // One word of slot memory: used bit, live-mapping bit and owner key.
  typedef struct packed {
    logic             used;
    logic             valid;
    logic [KEY_W-1:0] owner;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Which result the datapath records.
  typedef enum logic [1:0] {
    RES_NEW  = 2'd0,
    RES_KEY  = 2'd1,
    RES_FULL = 2'd2,
    RES_MISS = 2'd3
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clear;
    logic     load;
    logic     mod_step;
    logic     scan_step;
    logic     drop;
    logic     commit;
    logic     evict;
    logic     res_load;
    res_sel_t res_sel;
    logic     push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_reserve;
    logic is_lookup;
    logic is_evict;
    logic free_zero;
    logic mod_last;
    logic scan_done;
    logic key_found;
    logic free_found;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/hpca_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpca_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hpca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hpca_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpca_dp: allocator datapath
// Slot memory, chunk count and free count, bit-serial modulo unit, slot scan
// with match and free-slot tracking, result and response registers.
// ----------------------------------------------------------------------------
module hpca_dp #(
  parameter int MAX_CHUNKS  = 256,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hpca_pkg::req_t             req,
  input  logic                       cfg_we,
  input  logic [hpca_pkg::CFG_W-1:0] cfg_data,
  input  hpca_pkg::cmd_t             cmd,
  output hpca_pkg::stat_t            stat,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output hpca_pkg::rsp_t             rsp
);

  localparam int IDX_W       = $clog2(MAX_CHUNKS);
  localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
  localparam int RW          = IDX_W + 1;
  localparam int BIT_W       = $clog2(hpca_pkg::KEY_W);
  localparam int RESET_COUNT = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;

  logic [CNT_W-1:0]           chunk_count;
  logic [CNT_W-1:0]           free_count;
  logic [CNT_W-1:0]           cfg_count;
  logic [IDX_W-1:0]           clr_addr;
  logic [hpca_pkg::MODE_W-1:0] mode_q;
  logic [hpca_pkg::KEY_W-1:0] key_q;
  logic [BIT_W-1:0]           bit_cnt;
  logic [IDX_W-1:0]           rem;
  logic [IDX_W-1:0]           rem_next;
  logic [RW-1:0]              rem_trial;
  logic [RW-1:0]              count_ext;
  logic [CNT_W-1:0]           scan_addr;
  logic                       issue;
  logic                       rd_vld;
  logic [IDX_W-1:0]           rd_addr;
  hpca_pkg::slot_t            rd_slot;
  logic [hpca_pkg::SLOT_W-1:0] ram_rdata;
  logic                       hi_found;
  logic                       lo_found;
  logic                       key_found;
  logic [IDX_W-1:0]           hi_slot;
  logic [IDX_W-1:0]           lo_slot;
  logic [IDX_W-1:0]           key_slot;
  logic [IDX_W-1:0]           new_slot;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  hpca_pkg::slot_t            ram_wslot;
  logic [hpca_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]           res_idx;
  logic [hpca_pkg::OFFSET_W-1:0] offset_sum;

  // Clamp a written count into one to MAX_CHUNKS.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_count = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_CHUNKS)) begin
      cfg_count = CNT_W'(MAX_CHUNKS);
    end else begin
      cfg_count = CNT_W'(cfg_data);
    end
  end

  // Chunk count and free count; a count write reloads both.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= CNT_W'(RESET_COUNT);
      free_count  <= CNT_W'(RESET_COUNT);
    end else if (cfg_we) begin
      chunk_count <= cfg_count;
      free_count  <= cfg_count;
    end else if (cmd.commit) begin
      free_count <= free_count - CNT_W'(1);
    end else if (cmd.evict && (free_count < chunk_count)) begin
      free_count <= free_count + CNT_W'(1);
    end
  end

  // Clearing pass address; restarts on reset and on every count write.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= req.mode;
      key_q  <= req.number;
    end
  end

  // One restoring step of key modulo chunk count, most significant bit first.
  always_comb begin
    count_ext = RW'(chunk_count);
    rem_trial = {rem, key_q[bit_cnt]};
    if (rem_trial >= count_ext) begin
      rem_next = IDX_W'(rem_trial - count_ext);
    end else begin
      rem_next = IDX_W'(rem_trial);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_cnt <= '1;
      rem     <= '0;
    end else if (cmd.mod_step) begin
      bit_cnt <= bit_cnt - BIT_W'(1);
      rem     <= rem_next;
    end
  end

  // Scan read issue: one slot per cycle from zero up to one below the chunk count.
  assign issue = cmd.scan_step && (scan_addr < chunk_count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_addr <= '0;
    end else if (issue) begin
      scan_addr <= scan_addr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue && !cfg_we;
    end
    rd_addr <= scan_addr[IDX_W-1:0];
  end

  assign rd_slot = hpca_pkg::slot_t'(ram_rdata);

  // Track the first free slot at or above the probe start, the first free
  // slot overall (the wrapped probe) and the slot that holds the key.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_found  <= 1'b0;
      lo_found  <= 1'b0;
      key_found <= 1'b0;
    end else if (rd_vld) begin
      if (!rd_slot.used && !hi_found && (rd_addr >= rem)) begin
        hi_found <= 1'b1;
        hi_slot  <= rd_addr;
      end
      if (!rd_slot.used && !lo_found) begin
        lo_found <= 1'b1;
        lo_slot  <= rd_addr;
      end
      if (rd_slot.valid && (rd_slot.owner == key_q) && !key_found) begin
        key_found <= 1'b1;
        key_slot  <= rd_addr;
      end
    end
  end

  assign new_slot = hi_found ? hi_slot : lo_slot;

  // Memory write source selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wslot = '0;
    if (cmd.clear) begin
      ram_we = 1'b1;
    end else if (cmd.drop) begin
      ram_we          = 1'b1;
      ram_waddr       = key_slot;
      ram_wslot.used  = 1'b1;
      ram_wslot.owner = key_q;
    end else if (cmd.commit) begin
      ram_we          = 1'b1;
      ram_waddr       = new_slot;
      ram_wslot.used  = 1'b1;
      ram_wslot.valid = 1'b1;
      ram_wslot.owner = key_q;
    end else if (cmd.evict) begin
      ram_we    = 1'b1;
      ram_waddr = key_slot;
    end
  end

  hpca_ram #(
    .WIDTH (hpca_pkg::SLOT_W),
    .DEPTH (MAX_CHUNKS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        hpca_pkg::RES_NEW: begin
          res_status <= hpca_pkg::ST_OK;
          res_idx    <= new_slot;
        end
        hpca_pkg::RES_KEY: begin
          res_status <= hpca_pkg::ST_OK;
          res_idx    <= key_slot;
        end
        hpca_pkg::RES_FULL: begin
          res_status <= hpca_pkg::ST_FULL;
          res_idx    <= '0;
        end
        hpca_pkg::RES_MISS: begin
          res_status <= hpca_pkg::ST_NOT_FOUND;
          res_idx    <= '0;
        end
        default: begin
          res_status <= hpca_pkg::ST_NOT_FOUND;
          res_idx    <= '0;
        end
      endcase
    end
  end

  // Byte offset of the slot, kept to the low offset bits.
  assign offset_sum = hpca_pkg::OFFSET_W'(chunk_count)
                    + hpca_pkg::OFFSET_W'(hpca_pkg::HEADER_BYTES)
                    + hpca_pkg::OFFSET_W'(res_idx) * hpca_pkg::OFFSET_W'(CHUNK_BYTES);

  // Response register; a new response loads as the old one transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.status      <= res_status;
      rsp.slot_index  <= hpca_pkg::INDEX_W'(res_idx);
      rsp.byte_offset <= (res_status == hpca_pkg::ST_OK) ? offset_sum : '0;
    end
  end

  // Status toward the controller.
  assign stat.is_reserve = (mode_q == hpca_pkg::MODE_RESERVE);
  assign stat.is_lookup  = (mode_q == hpca_pkg::MODE_LOOKUP);
  assign stat.is_evict   = (mode_q == hpca_pkg::MODE_EVICT);
  assign stat.free_zero  = (free_count == '0);
  assign stat.mod_last   = (bit_cnt == '0);
  assign stat.scan_done  = (scan_addr >= chunk_count) && !rd_vld;
  assign stat.key_found  = key_found;
  assign stat.free_found = hi_found || lo_found;
  assign stat.clr_last   = (clr_addr == IDX_W'(MAX_CHUNKS - 1));
  assign stat.out_free   = !rsp_valid || rsp_ready;

  // The free count never runs past the chunk count.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= chunk_count)
    else $error("free count above chunk count");

  // A scan read never lands beyond the slots in use.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CNT_W'(rd_addr) < chunk_count))
    else $error("scan read outside the slot range");

  // A failed request carries a zero index and offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != hpca_pkg::ST_OK)) |->
      ((rsp.slot_index == '0) && (rsp.byte_offset == '0)))
    else $error("failed response with nonzero slot fields");

endmodule

// ----- rtl/core/hpca_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpca_ctrl: allocator controller
// Sequences the clearing pass, request capture, modulo, slot scan, memory
// update and response hand-off through command and status bundles.
// ----------------------------------------------------------------------------
module hpca_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic            cfg_we,
  input  hpca_pkg::stat_t stat,
  output hpca_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DECIDE = 8'b0000_0100,
    ST_MOD    = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_APPLY  = 8'b0010_0000,
    ST_COMMIT = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE) && !cfg_we;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.res_sel = hpca_pkg::RES_MISS;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_reserve) begin
          if (stat.free_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = hpca_pkg::RES_FULL;
            state_next   = ST_RESP;
          end else begin
            state_next = ST_MOD;
          end
        end else if (stat.is_lookup || stat.is_evict) begin
          state_next = ST_SCAN;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = hpca_pkg::RES_MISS;
          state_next   = ST_RESP;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (stat.is_reserve) begin
          if (!stat.free_found) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = hpca_pkg::RES_FULL;
            state_next   = ST_RESP;
          end else begin
            // An older mapping of the key loses its live bit; the slot stays used.
            cmd.drop   = stat.key_found;
            state_next = ST_COMMIT;
          end
        end else if (stat.key_found) begin
          cmd.evict    = stat.is_evict;
          cmd.res_load = 1'b1;
          cmd.res_sel  = hpca_pkg::RES_KEY;
          state_next   = ST_RESP;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = hpca_pkg::RES_MISS;
          state_next   = ST_RESP;
        end
      end
      ST_COMMIT: begin
        cmd.commit   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = hpca_pkg::RES_NEW;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // A count write starts a fresh clearing pass.
    if (cfg_we) begin
      state_next = ST_CLEAR;
    end
  end

  // Only one source writes the slot memory in a cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.drop, cmd.commit, cmd.evict}))
    else $error("more than one slot memory writer");

  // A captured request is decided in the following cycle.
  a_load_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DECIDE))
    else $error("request capture not followed by decode");

  // Handing off a response returns the controller to idle.
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !cfg_we) |=> (state == ST_IDLE))
    else $error("response hand-off did not return to idle");

endmodule

// ----- rtl/core/hashed_probe_chunk_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_probe_chunk_allocator: linear-probing chunk slot allocator
// Reserves, looks up and evicts chunk slots keyed by a 64-bit table number.
// ----------------------------------------------------------------------------
// One request is in work at a time. A reserve first runs the bit-serial
// modulo unit that finds the probe start, then scans one slot per cycle
// through the single read port of the slot memory,
// which finds the probed free slot and any older mapping of the key in the
// same pass. Lookup and evict skip the modulo and go straight to the scan; a
// reserve with no free slots left and an unknown mode skip both and go
// straight to the response. The next request is taken while a response still
// waits on the response port. After reset and after every chunk_count write
// the block runs a clearing pass over all MAX_CHUNKS slots of the slot memory
// and takes no request until it ends.
module hashed_probe_chunk_allocator #(
  parameter int MAX_CHUNKS  = 256,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  hpca_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output hpca_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [hpca_pkg::CFG_W-1:0] cfg_data
);

  hpca_pkg::cmd_t  cmd;
  hpca_pkg::stat_t stat;

  // Controller.
  hpca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  hpca_dp #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
